### hdl/mt19937_random_generator_assert.svh
// Assertion macros used by the generator's checker, mtg_checker.
// Both sample on clk and stay quiet while arst_n is low.
`ifndef MT19937_RANDOM_GENERATOR_ASSERT_SVH
`define MT19937_RANDOM_GENERATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MTG_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mtg assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define MTG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mtg assertion failed");

`endif

### hdl/mtg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mtg_pkg;

	localparam int MT_N = 624;
	localparam int MT_M = 397;
	localparam int ADDR_W = 10;

	typedef logic [31:0] word_t;
	typedef logic [ADDR_W-1:0] addr_t;

	localparam word_t MATRIX_A = 32'h9908_B0DF;
	localparam word_t UPPER_MASK = 32'h8000_0000;
	localparam word_t LOWER_MASK = 32'h7FFF_FFFF;
	localparam word_t INIT_MULT = 32'd1812433253;
	localparam word_t TEMPER_B = 32'h9D2C_5680;
	localparam word_t TEMPER_C = 32'hEFC6_0000;

	typedef enum logic [1:0] {
		OP_GENERATE = 2'd0,
		OP_RESEED   = 2'd1,
		OP_RESET    = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_SEED,
		ST_IDLE,
		ST_RD_IJ,
		ST_RD_K,
		ST_TWIST,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

### hdl/mtg_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mtg_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [31:0] seed;

	modport source (output valid, output op, output seed, input ready);
	modport sink (input valid, input op, input seed, output ready);
endinterface

`default_nettype wire

### hdl/mtg_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mtg_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] random_value;

	modport source (output valid, output random_value, input ready);
	modport sink (input valid, input random_value, output ready);
endinterface

`default_nettype wire

### hdl/mt19937_random_generator.sv
`timescale 1ns / 1ps
`default_nettype none

// Generate, per 32-bit word: read i and j, read k, twist and write back; then the output
// register is loaded, held while the previous result still waits. A new request is taken
// only once the block is back in idle, after the result has been loaded.
// Reseed and reset: all 624 state words are written, one per cycle, and no request is taken
// meanwhile. After arst_n the block runs the same seeding with seed zero, not ready.
module mt19937_random_generator #(
	parameter int VALUE_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	mtg_req_if.sink    req,
	mtg_rsp_if.source  rsp
);

	import mtg_pkg::*;

	localparam int NWORDS = (VALUE_BITS + 31) / 32;
	localparam logic [63:0] MASK64 =
		(VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
	localparam word_t VALUE_MASK = MASK64[31:0];
	localparam logic LAST_WORD = 1'(NWORDS - 1);

	state_t state_q, state_d;
	addr_t  pos_q;
	logic   pos_wrap_q;
	addr_t  idx_q;
	word_t  seed_q;
	word_t  prev_q;
	word_t  y_q;
	word_t  result_q;
	logic   word_cnt_q;
	logic   out_valid_q;
	word_t  out_data_q;

	addr_t  cur_i;
	addr_t  nxt_j;
	addr_t  k_addr;
	logic [ADDR_W:0] k_sum;
	word_t  mix;
	word_t  seed_word;
	word_t  twisted;
	word_t  t1, t2, t3, tempered;
	word_t  y_d;
	logic   out_free;

	logic   wr_en;
	addr_t  wr_addr;
	word_t  wr_data;
	addr_t  rd_addr_a;
	addr_t  rd_addr_b;
	word_t  rd_data_a;
	word_t  rd_data_b;

	mtg_ram #(
		.WIDTH(32),
		.DEPTH(MT_N)
	) u_state_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	// Position 624 (after a reseed) restarts at word zero.
	always_comb begin
		cur_i = pos_wrap_q ? '0 : pos_q;
		nxt_j = (cur_i == ADDR_W'(MT_N - 1)) ? '0 : cur_i + addr_t'(1);
		k_sum = {1'b0, cur_i} + (ADDR_W + 1)'(MT_M);
		k_addr = (k_sum >= (ADDR_W + 1)'(MT_N)) ? ADDR_W'(k_sum - (ADDR_W + 1)'(MT_N))
		                                          : k_sum[ADDR_W-1:0];
	end

	always_comb begin
		mix = prev_q ^ (prev_q >> 30);
		seed_word = (idx_q == '0) ? seed_q : (INIT_MULT * mix) + word_t'(idx_q);
		y_d = (rd_data_a & UPPER_MASK) | (rd_data_b & LOWER_MASK);
		twisted = rd_data_a ^ (y_q >> 1) ^ (y_q[0] ? MATRIX_A : '0);
		t1 = twisted ^ (twisted >> 11);
		t2 = t1 ^ ((t1 << 7) & TEMPER_B);
		t3 = t2 ^ ((t2 << 15) & TEMPER_C);
		tempered = t3 ^ (t3 >> 18);
		out_free = !out_valid_q || rsp.ready;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_SEED: begin
				if (idx_q == ADDR_W'(MT_N - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req.valid) begin
					case (op_t'(req.op))
						OP_GENERATE: state_d = ST_RD_IJ;
						OP_RESEED:   state_d = ST_SEED;
						OP_RESET:    state_d = ST_SEED;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_RD_IJ: state_d = ST_RD_K;
			ST_RD_K:  state_d = ST_TWIST;
			ST_TWIST: state_d = (word_cnt_q == LAST_WORD) ? ST_OUT : ST_RD_IJ;
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_SEED;
		endcase
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = cur_i;
		wr_data = twisted;
		rd_addr_a = cur_i;
		rd_addr_b = nxt_j;
		req.ready = 1'b0;
		case (state_q)
			ST_SEED: begin
				wr_en = 1'b1;
				wr_addr = idx_q;
				wr_data = seed_word;
			end
			ST_IDLE: req.ready = 1'b1;
			ST_RD_IJ: begin
				rd_addr_a = cur_i;
				rd_addr_b = nxt_j;
			end
			ST_RD_K: rd_addr_a = k_addr;
			ST_TWIST: wr_en = 1'b1;
			ST_OUT: ;
			default: ;
		endcase
		rsp.valid = out_valid_q;
		rsp.random_value = out_data_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SEED;
			pos_q <= '0;
			pos_wrap_q <= 1'b1;
			idx_q <= '0;
			seed_q <= '0;
			word_cnt_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Load a finished value, else drop the one just transferred.
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
				out_data_q <= result_q & VALUE_MASK;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_SEED: begin
					prev_q <= seed_word;
					idx_q <= idx_q + addr_t'(1);
					if (idx_q == ADDR_W'(MT_N - 1)) begin
						pos_wrap_q <= 1'b1;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						idx_q <= '0;
						word_cnt_q <= 1'b0;
						seed_q <= (op_t'(req.op) == OP_RESEED) ? (req.seed & VALUE_MASK) : '0;
					end
				end
				ST_RD_IJ: ;
				ST_RD_K: y_q <= y_d;
				ST_TWIST: begin
					// Advance to the next word, wrapping at the end of the state.
					pos_q <= nxt_j;
					pos_wrap_q <= 1'b0;
					if (word_cnt_q == 1'b0) begin
						result_q <= tempered;
					end
					word_cnt_q <= word_cnt_q + 1'b1;
				end
				ST_OUT: ;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

### hdl/mtg_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mtg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr_a,
	input  logic [AW-1:0]    rd_addr_b,
	output logic [WIDTH-1:0] rd_data_a,
	output logic [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

`default_nettype wire

### hdl/mtg_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "mt19937_random_generator_assert.svh"

module mtg_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic [1:0]  req_op,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [31:0] rsp_random_value
);

	import mtg_pkg::*;

	logic req_xfer;
	logic req_known;

	assign req_xfer = req_valid && req_ready;
	assign req_known = (req_op == OP_GENERATE) || (req_op == OP_RESEED) || (req_op == OP_RESET);

	// A held result keeps its value until the transfer.
	`MTG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_random_value))
	// Any real request makes the block busy in the cycle after its transfer.
	`MTG_ASSERT_NEXT(a_busy_after_req, req_xfer && req_known, !req_ready)
	// The seeding pass after reset keeps the block busy.
	`MTG_ASSERT_SAME(a_seed_after_reset, !$past(arst_n), !req_ready)
	// A reseed or reset request never produces a result.
	`MTG_ASSERT_NEXT(a_no_rsp_on_seed,
		req_xfer && (req_op == OP_RESEED || req_op == OP_RESET) && !rsp_valid, !rsp_valid)

endmodule

bind mt19937_random_generator mtg_checker u_mtg_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_op           (req.op),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_random_value (rsp.random_value)
);

`default_nettype wire

### sim/tb_mt19937_random_generator.sv
`timescale 1ns / 1ps

module tb_mt19937_random_generator;
	import mtg_pkg::*;

	localparam int OUT_BITS = 32;
	localparam int WORDS_PER_VALUE = (OUT_BITS + 31) / 32;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 1100;
	localparam int CALM_TAIL = 150;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 40;

	// Tracks the twister state and holds the random values still to come back.
	class mt_sequence_tracker;
		word_t state_words[MT_N];
		int unsigned draw_pos;
		word_t expected_values[$];
		int unsigned errors;

		function new();
			errors = 0;
			load_seed('0);
		endfunction

		function void load_seed(word_t s);
			state_words[0] = s;
			for (int i = 1; i < MT_N; i++) begin
				state_words[i] = INIT_MULT * (state_words[i-1] ^ (state_words[i-1] >> 30))
					+ word_t'(i);
			end
			draw_pos = MT_N;
		endfunction

		function word_t draw_word();
			int unsigned i, j, k;
			word_t y, w;
			if (draw_pos >= MT_N)
				draw_pos = 0;
			i = draw_pos;
			j = (i + 1) % MT_N;
			k = (i + MT_M) % MT_N;
			y = (state_words[i] & UPPER_MASK) | (state_words[j] & LOWER_MASK);
			w = state_words[k] ^ (y >> 1) ^ (y[0] ? MATRIX_A : word_t'(0));
			state_words[i] = w;
			draw_pos = i + 1;
			w ^= w >> 11;
			w ^= (w << 7) & TEMPER_B;
			w ^= (w << 15) & TEMPER_C;
			w ^= w >> 18;
			return w;
		endfunction

		function void note_request(logic [1:0] op, word_t seed);
			logic [63:0] value;
			logic [63:0] word;
			word_t s;
			case (op)
			OP_GENERATE: begin
				value = '0;
				for (int w = 0; w < WORDS_PER_VALUE; w++) begin
					word = {32'd0, draw_word()};
					if (w < 2)
						value |= word << (32 * w);
				end
				if (OUT_BITS < 64)
					value &= (64'd1 << OUT_BITS) - 64'd1;
				expected_values.push_back(value[31:0]);
			end
			OP_RESEED: begin
				s = seed;
				if (OUT_BITS < 32)
					s &= word_t'((64'd1 << OUT_BITS) - 64'd1);
				load_seed(s);
			end
			OP_RESET: begin
				load_seed('0);
			end
			default: begin
				// unused code: state stays as it is
			end
			endcase
		endfunction

		function void check_value(word_t actual);
			word_t want;
			if (expected_values.size() == 0) begin
				$display("%0t: random_value expected none, actual %08h", $time, actual);
				errors++;
				return;
			end
			want = expected_values.pop_front();
			if (actual !== want) begin
				$display("%0t: random_value expected %08h, actual %08h", $time, want, actual);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return expected_values.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	mtg_req_if req_ch();
	mtg_rsp_if rsp_ch();

	mt19937_random_generator #(
		.VALUE_BITS(OUT_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	mt_sequence_tracker tracker = new();
	bit allow_idle = 1'b1;
	int unsigned gap_odds = 4;
	int unsigned requests_sent = 0;
	int unsigned quiet_cycles = 0;

	always #5 clk = ~clk;

	task automatic send_request(input logic [1:0] op, input word_t seed);
		int unsigned gap;
		gap = 0;
		if (allow_idle && gap_odds != 0 && $urandom_range(gap_odds - 1) == 0)
			gap = $urandom_range(14, 1);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.seed <= seed;
		do @(posedge clk); while (!req_ch.ready);
		tracker.note_request(op, seed);
		if (op != OP_UNUSED)
			requests_sent++;
	endtask

	task automatic generate_run(input int unsigned count);
		for (int unsigned n = 0; n < count; n++) begin
			// seed is ignored here; toggle it anyway
			send_request(OP_GENERATE, $urandom);
		end
	endtask

	initial begin
		int unsigned choice;
		int unsigned bit_pos;
		req_ch.valid <= 1'b0;
		req_ch.op <= OP_GENERATE;
		req_ch.seed <= '0;
		rsp_ch.ready <= 1'b0;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// power-up state, first twist
		generate_run(3);
		send_request(OP_UNUSED, $urandom);
		generate_run(1);
		send_request(OP_RESEED, 32'hFFFF_FFFF);
		generate_run(2);
		send_request(OP_RESEED, 32'h0000_0000);
		generate_run(1);
		send_request(OP_RESEED, 32'd5489);
		generate_run(2);
		send_request(OP_RESEED, 32'h8000_0001);
		generate_run(1);
		send_request(OP_RESET, 32'h5A5A_A5A5);
		generate_run(1);
		// reset straight after a reseed must win
		send_request(OP_RESEED, 32'h0000_0001);
		send_request(OP_RESET, 32'hFFFF_FFFF);
		generate_run(1);
		send_request(OP_UNUSED, 32'hFFFF_FFFF);
		generate_run(1);

		// long draw run, crosses the wrap of the word position
		for (int n = 0; n < 650; n++) begin
			if (n % 50 == 0)
				gap_odds = $urandom_range(3) * 3;
			if ($urandom_range(49) == 0)
				send_request(OP_UNUSED, $urandom);
			send_request(OP_GENERATE, $urandom);
		end

		while (requests_sent < ITEM_TARGET) begin
			if (requests_sent + CALM_TAIL >= ITEM_TARGET)
				allow_idle = 1'b0;
			else
				gap_odds = $urandom_range(3) * 3;
			choice = $urandom_range(99);
			bit_pos = $urandom_range(31);
			if (choice < 60) begin
				send_request(OP_RESEED, $urandom);
			end else if (choice < 75) begin
				send_request(OP_RESET, $urandom);
			end else if (choice < 85) begin
				case ($urandom_range(3))
				0: send_request(OP_RESEED, 32'h0000_0000);
				1: send_request(OP_RESEED, 32'hFFFF_FFFF);
				2: send_request(OP_RESEED, word_t'(1) << bit_pos);
				default: send_request(OP_RESEED, ~(word_t'(1) << bit_pos));
				endcase
			end else if (choice < 92) begin
				// broken sequence: back-to-back reseed or reset
				send_request($urandom_range(1) ? OP_RESEED : OP_RESET, $urandom);
				send_request(OP_RESEED, $urandom);
			end else begin
				send_request(OP_UNUSED, $urandom);
			end
			generate_run($urandom_range(40, 1));
		end

		req_ch.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// result side back-pressure
	initial begin
		@(posedge clk);
		forever begin
			if (allow_idle && $urandom_range(3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(14, 1)) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(20, 1)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			tracker.check_value(rsp_ch.random_value);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

endmodule

### sim.f
+incdir+hdl
hdl/mtg_pkg.sv
hdl/mtg_req_if.sv
hdl/mtg_rsp_if.sv
hdl/mtg_ram.sv
hdl/mt19937_random_generator.sv
hdl/mtg_checker.sv
sim/tb_mt19937_random_generator.sv
